// ----- rtl/core/edf_pkg.sv -----
// echo distance filter package: constants, widths and shared types
// no dependencies
package edf_pkg;

   localparam int DIST_W      = 14;
   localparam int ECHO_W      = 15;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 14;
   localparam int RING_DEPTH_DEF = 5;

   localparam logic [13:0] SPEED_MUL    = 14'd8993;
   localparam int          SPEED_SHIFT  = 15;
   localparam logic [13:0] THRESH_RESET = 14'd320;
   localparam logic [13:0] MAXD_RESET   = 14'd6400;
   localparam int          VAR_LIMIT    = 6400;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST  = 1'd1;

   typedef struct packed {
      logic [DIST_W-1:0] filtered_distance;
      logic              obstacle_seen;
      logic              readings_stable;
      logic              reading_accepted;
   } rsp_type;

   typedef struct packed {
      logic [ECHO_W-1:0] echo_duration;
      logic              clear_filter;
   } req_type;

endpackage

// ----- rtl/core/edf_req_if.sv -----
// request channel interface, valid/ready with one echo transaction
// depends on edf_pkg
interface edf_req_if;
   import edf_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/edf_rsp_if.sv -----
// response channel interface, valid/ready with one filter result transaction
// depends on edf_pkg
interface edf_rsp_if;
   import edf_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/echo_distance_filter.sv -----
// echo distance filter: an accepted reading passes through the bit-serial multiplier (conversion,
// then a scan that squares each of the D = RING_DEPTH ring slots, then the ring sum squared) and
// then the serial divider for the mean before the response; a rejected reading goes straight
// from conversion to the response
// one transaction in flight; next request taken the cycle after the response is taken
// synchronous active-high reset empties the ring and held values, registers to defaults
// depends on edf_pkg, edf_req_if, edf_rsp_if, edf_serial_mul, edf_serial_div
module echo_distance_filter #(
   parameter int RING_DEPTH = edf_pkg::RING_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   edf_req_if.sink                         req,
   edf_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [edf_pkg::CSR_IDX_W-1:0]   csr_idx,
   input  logic [edf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import edf_pkg::*;

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int SUM_W  = DIST_W + CNT_W;
   localparam int SQ_W   = 2 * DIST_W;
   localparam int SQS_W  = SQ_W + CNT_W;
   localparam int SS_W   = 2 * SUM_W;
   localparam int LHS_W  = SQS_W + CNT_W;
   localparam int CMP_W  = (LHS_W > SS_W) ? LHS_W + 1 : SS_W + 1;
   localparam int MUL_W  = (SUM_W > ECHO_W) ? SUM_W : ECHO_W;
   localparam int PROD_W = 2 * MUL_W;
   localparam int LIMIT  = RING_DEPTH * RING_DEPTH * VAR_LIMIT;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_SQR  = 3'd3;
   localparam logic [2:0] ST_SS   = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [DIST_W-1:0]   ring_ff [RING_DEPTH];
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [DIST_W-1:0]   thresh_ff, maxd_ff;
   logic [DIST_W-1:0]   held_dist_ff, held_dist_in;
   logic                held_obs_ff, held_obs_in;
   logic                held_stab_ff, held_stab_in;
   logic                acc_ff, acc_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SQS_W-1:0]    sqs_ff, sqs_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                ring_we;
   logic [SLOT_W-1:0]   ring_wa;
   logic [DIST_W-1:0]   ring_wd;
   logic                ring_clr;

   logic                mul_start, mul_done;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [PROD_W-1:0]   mul_p;
   logic                div_start, div_done;
   logic [SUM_W-1:0]    div_q;
   logic [ECHO_W+DIST_W-1:0] conv_p;
   logic [DIST_W:0]     conv_dist;
   logic [DIST_W-1:0]   cur;
   logic [LHS_W-1:0]    lhs;
   logic [CMP_W-1:0]    diff;
   logic                req_fire;

   assign req_fire  = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign cur       = ring_ff[idx_ff];
   assign conv_p    = (ECHO_W+DIST_W)'(mul_p);
   assign conv_dist = (DIST_W+1)'(conv_p >> SPEED_SHIFT);
   assign lhs       = LHS_W'(sqs_ff * RING_DEPTH);
   assign diff      = CMP_W'(lhs) - CMP_W'(mul_p);

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      held_dist_in = held_dist_ff;
      held_obs_in  = held_obs_ff;
      held_stab_in = held_stab_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      sqs_in       = sqs_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ring_we      = 1'b0;
      ring_wa      = slot_ff;
      ring_wd      = conv_dist[DIST_W-1:0];
      ring_clr     = 1'b0;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.data.clear_filter) begin
                  ring_clr     = 1'b1;
                  slot_in      = '0;
                  held_stab_in = 1'b0;
               end
               mul_start = 1'b1;
               mul_a     = MUL_W'(req.data.echo_duration);
               mul_b     = MUL_W'(SPEED_MUL);
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            if (mul_done) begin
               if (conv_dist != '0 && conv_dist <= {1'b0, maxd_ff}) begin
                  ring_we  = 1'b1;
                  slot_in  = (slot_ff == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
                  acc_in   = 1'b1;
                  idx_in   = '0;
                  sum_in   = '0;
                  cnt_in   = '0;
                  sqs_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  acc_in   = 1'b0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_SCAN: begin
            sum_in = sum_ff + SUM_W'(cur);
            if (cur != '0) cnt_in = cnt_ff + 1'b1;
            mul_start   = 1'b1;
            mul_a       = MUL_W'(cur);
            mul_b       = MUL_W'(cur);
            state_in    = ST_SQR;
         end
         ST_SQR: begin
            if (mul_done) begin
               sqs_in = sqs_ff + SQS_W'(mul_p);
               if (idx_ff == SLOT_W'(RING_DEPTH - 1)) begin
                  mul_start = 1'b1;
                  mul_a     = MUL_W'(sum_ff);
                  mul_b     = MUL_W'(sum_ff);
                  state_in  = ST_SS;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SS: begin
            if (mul_done) begin
               held_stab_in = (ring_ff[0] != '0) &&
                  (diff[CMP_W-1] || (diff < CMP_W'(LIMIT)));
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               held_dist_in = (cnt_ff == '0) ? '0 : DIST_W'(div_q);
               held_obs_in  = (held_dist_in != '0) && (held_dist_in < thresh_ff);
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_in.filtered_distance = held_dist_ff;
            rsp_in.obstacle_seen     = held_obs_ff;
            rsp_in.readings_stable   = held_stab_ff;
            rsp_in.reading_accepted  = acc_ff;
            rsp_valid_in             = 1'b1;
            state_in                 = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   edf_serial_mul #(.A_W(MUL_W), .B_W(MUL_W), .P_W(PROD_W)) u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .prod (mul_p)
   );

   edf_serial_div #(.N_W(SUM_W), .D_W(CNT_W)) u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (sum_ff), .den ((cnt_ff == '0) ? CNT_W'(1) : cnt_ff),
      .done (div_done), .quo (div_q)
   );

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      sum_ff <= sum_in;
      cnt_ff <= cnt_in;
      sqs_ff <= sqs_in;
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         held_dist_ff <= '0;
         held_obs_ff  <= 1'b0;
         held_stab_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= THRESH_RESET;
         maxd_ff      <= MAXD_RESET;
         for (int i = 0; i < RING_DEPTH; i++) ring_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         held_dist_ff <= held_dist_in;
         held_obs_ff  <= held_obs_in;
         held_stab_ff <= held_stab_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_idx)
               CSR_THRESHOLD: thresh_ff <= csr_wdata;
               CSR_MAX_DIST:  maxd_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (ring_clr) begin
            for (int i = 0; i < RING_DEPTH; i++) ring_ff[i] <= '0;
         end else if (ring_we) begin
            ring_ff[ring_wa] <= ring_wd;
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> (state_ff == ST_IDLE)) else $error("ready outside idle");
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req.ready) else $error("second transaction taken while busy");
   a_obs_dist: assert property (@(posedge clock) disable iff (reset)
      held_obs_ff |-> (held_dist_ff != '0)) else $error("obstacle with zero distance");
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(RING_DEPTH - 1)) else $error("write slot out of range");
endmodule

// ----- rtl/core/edf_serial_mul.sv -----
// bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle
// depends on nothing; used by the echo distance filter top level
module edf_serial_mul #(
   parameter int A_W = 15,
   parameter int B_W = 15,
   parameter int P_W = 30
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   output logic           done,
   output logic [P_W-1:0] prod
);
   localparam int CNT_W = $clog2(B_W + 1);

   logic [P_W-1:0]   acc_ff, acc_in;
   logic [P_W-1:0]   mcand_ff, mcand_in;
   logic [B_W-1:0]   mplier_ff, mplier_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = P_W'(a);
         mplier_in = b;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

// ----- rtl/core/edf_serial_div.sv -----
// restoring serial divider, one quotient bit per cycle
// depends on nothing; used by the echo distance filter top level
module edf_serial_div #(
   parameter int N_W = 18,
   parameter int D_W = 5
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic           done,
   output logic [N_W-1:0] quo
);
   localparam int CNT_W = $clog2(N_W + 1);

   logic [N_W-1:0]   q_ff, q_in;
   logic [D_W:0]     r_ff, r_in;
   logic [D_W-1:0]   d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[D_W-1:0], q_ff[N_W-1]};
      if (start) begin
         q_in    = num;
         r_in    = '0;
         d_in    = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[N_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

// ----- tb/edf_checker.sv -----
// echo distance filter checker: watches request and response channels, predicts and compares
// depends on edf_pkg, edf_req_if, edf_rsp_if
module edf_checker #(
   parameter int RING_DEPTH = edf_pkg::RING_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   edf_req_if                              req,
   edf_rsp_if                              rsp,
   input  logic                            csr_we,
   input  logic [edf_pkg::CSR_IDX_W-1:0]   csr_idx,
   input  logic [edf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending_count,
   output int                              accepted_count
);
   import edf_pkg::*;

   logic [DIST_W-1:0] thresh_reg, maxd_reg;
   logic [DIST_W-1:0] ring [RING_DEPTH];
   int                slot;
   logic [DIST_W-1:0] held_dist;
   logic              held_obst, held_stab;
   rsp_type           expected_q [$];

   function automatic logic [DIST_W-1:0] ring_mean();
      int unsigned total, n;
      total = 0;
      n = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         if (ring[i] != 0) begin
            total += ring[i];
            n++;
         end
      end
      return (n == 0) ? '0 : DIST_W'(total / n);
   endfunction

   function automatic logic ring_is_stable();
      longint unsigned s, sq, lhs, rhs;
      s = 0;
      sq = 0;
      if (ring[0] == 0) return 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         s += ring[i];
         sq += longint'(ring[i]) * ring[i];
      end
      lhs = RING_DEPTH * sq;
      rhs = s * s;
      if (lhs < rhs) return 1'b1;
      return (lhs - rhs) < longint'(RING_DEPTH * RING_DEPTH * VAR_LIMIT);
   endfunction

   task automatic predict_filter(input req_type item);
      logic [31:0] range_val;
      rsp_type     r;
      r.reading_accepted = 1'b0;
      if (item.clear_filter) begin
         for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
         slot = 0;
         held_stab = 1'b0;
      end
      range_val = (32'(item.echo_duration) * 32'(SPEED_MUL)) >> SPEED_SHIFT;
      if (range_val != 0 && range_val <= maxd_reg) begin
         ring[slot] = range_val[DIST_W-1:0];
         slot = (slot + 1) % RING_DEPTH;
         held_dist = ring_mean();
         held_obst = held_dist > 0 && held_dist < thresh_reg;
         held_stab = ring_is_stable();
         r.reading_accepted = 1'b1;
      end
      r.filtered_distance = held_dist;
      r.obstacle_seen = held_obst;
      r.readings_stable = held_stab;
      expected_q.push_back(r);
   endtask

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      if (reset) begin
         thresh_reg <= THRESH_RESET;
         maxd_reg <= MAXD_RESET;
         for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
         slot = 0;
         held_dist = '0;
         held_obst = 1'b0;
         held_stab = 1'b0;
         expected_q.delete();
         fail_count <= 0;
         accepted_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_idx == CSR_THRESHOLD) thresh_reg <= csr_wdata;
            else if (csr_idx == CSR_MAX_DIST) maxd_reg <= csr_wdata;
         end
         if (req.valid && req.ready) predict_filter(req.data);
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp.data);
               fail_count <= fail_count + 1;
            end else begin
               rsp_type e;
               e = expected_q.pop_front();
               if (rsp.data.reading_accepted) accepted_count <= accepted_count + 1;
               if (e.filtered_distance !== rsp.data.filtered_distance
                   || e.obstacle_seen !== rsp.data.obstacle_seen
                   || e.readings_stable !== rsp.data.readings_stable
                   || e.reading_accepted !== rsp.data.reading_accepted) begin
                  $display("%0t: mismatch expected dist=%0d obst=%b stab=%b acc=%b",
                           $time, e.filtered_distance, e.obstacle_seen,
                           e.readings_stable, e.reading_accepted);
                  $display("%0t:          actual dist=%0d obst=%b stab=%b acc=%b",
                           $time, rsp.data.filtered_distance, rsp.data.obstacle_seen,
                           rsp.data.readings_stable, rsp.data.reading_accepted);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- tb/tb_top.sv -----
// echo distance filter testbench top: clock, reset, stimulus, register phases and verdict
// depends on edf_pkg, edf_req_if, edf_rsp_if, echo_distance_filter, edf_checker
module tb_top;
   import edf_pkg::*;

   localparam int LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_idx = CSR_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int   fail_count, pending_count, accepted_count;
   int   cycles = 0;
   int   sent = 0;
   bit   stim_done = 1'b0;

   edf_req_if req ();
   edf_rsp_if rsp ();

   echo_distance_filter dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   edf_checker chk (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count),
      .accepted_count(accepted_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** echo_distance_filter: FAILED **");
         $finish;
      end
   end

   // response side: random stall before each transaction, with calm stretches
   initial begin
      int gap;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         rsp.ready <= 1'b0;
         repeat (gap) @(negedge clock);
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!(rsp.valid && rsp.ready));
      end
   end

   task automatic send_echo(input logic [ECHO_W-1:0] width, input logic clr, input bit idle);
      int gap;
      gap = idle ? $urandom_range(0, 9) : 0;
      repeat (gap) @(negedge clock);
      req.data.echo_duration <= width;
      req.data.clear_filter <= clr;
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      req.valid <= 1'b0;
      sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      csr_idx <= idx;
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // width for a distance near d sixteenths
   function automatic logic [ECHO_W-1:0] width_for(input int d);
      return ECHO_W'((d * 32768) / 8993 + 1);
   endfunction

   task automatic random_phase(input int n);
      int base;
      logic [ECHO_W-1:0] w;
      base = $urandom_range(50, 6000);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0:       w = ECHO_W'($urandom);
            1:       w = '0;
            2: begin
               base = $urandom_range(1, 9000);
               w = width_for(base);
            end
            default: w = width_for(base + $urandom_range(0, 40) - 20);
         endcase
         if ($urandom_range(0, 9) == 2) w = width_for(base);
         send_echo(w, $urandom_range(0, 24) == 0, $urandom_range(0, 7) != 0);
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: no echo, extremes, clears, stable run, obstacle
      send_echo('0, 1'b0, 1'b0);
      send_echo(15'd1, 1'b0, 1'b0);
      send_echo(15'd4, 1'b0, 1'b0);
      send_echo(15'd30000, 1'b0, 1'b0);
      send_echo(15'h7fff, 1'b0, 1'b0);
      send_echo(width_for(6400), 1'b0, 1'b0);
      send_echo(width_for(6400) + 15'd1, 1'b0, 1'b0);
      for (int i = 0; i < 6; i++) send_echo(width_for(100), 1'b0, 1'b1);
      send_echo(width_for(200), 1'b1, 1'b0);
      send_echo('0, 1'b1, 1'b0);
      for (int i = 0; i < 6; i++) send_echo(width_for(3000 + 30 * i), 1'b0, 1'b1);
      send_echo(width_for(5000), 1'b0, 1'b0);
      send_echo(15'h5555, 1'b1, 1'b0);
      send_echo(15'h2aaa, 1'b0, 1'b0);
      random_phase(300);

      write_reg(CSR_THRESHOLD, 14'h3fff);
      write_reg(CSR_MAX_DIST, 14'h3fff);
      random_phase(350);
      write_reg(CSR_THRESHOLD, '0);
      write_reg(CSR_MAX_DIST, '0);
      random_phase(40);
      write_reg(CSR_THRESHOLD, 14'd2000);
      write_reg(CSR_MAX_DIST, 14'd1);
      send_echo(15'd4, 1'b0, 1'b0);
      send_echo(15'd7, 1'b0, 1'b0);
      write_reg(CSR_MAX_DIST, 14'd4000);
      random_phase(350);
      write_reg(CSR_THRESHOLD, THRESH_RESET);
      write_reg(CSR_MAX_DIST, MAXD_RESET);
      random_phase(340);
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (pending_count != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      $display("sent %0d echo transactions, %0d readings entered the ring", sent, accepted_count);
      $display("register phases covered threshold and range limits at zero, default and full scale");
      if (fail_count == 0)
         $display("** echo_distance_filter: PASSED **");
      else
         $display("** echo_distance_filter: FAILED **");
      $finish;
   end
endmodule
